### rtl/ssat_pkg.sv
package ssat_pkg;

	localparam int NumPos = 6;

	// Segment patterns, gfedcba, decimal point excluded.
	localparam logic [6:0] SEG_MASK  = 7'h7F;
	localparam logic [7:0] SEG_POINT = 8'h80;
	localparam logic [6:0] SEG_D0    = 7'h3F;
	localparam logic [6:0] SEG_D1    = 7'h06;
	localparam logic [6:0] SEG_D2    = 7'h5B;
	localparam logic [6:0] SEG_D3    = 7'h4F;
	localparam logic [6:0] SEG_D4    = 7'h66;
	localparam logic [6:0] SEG_D5    = 7'h6D;
	localparam logic [6:0] SEG_D6    = 7'h7D;
	localparam logic [6:0] SEG_D7    = 7'h07;
	localparam logic [6:0] SEG_D8    = 7'h7F;
	localparam logic [6:0] SEG_D9    = 7'h6F;
	localparam logic [6:0] SEG_MINUS = 7'h40;

	// ASCII codes, cut to six bits.
	localparam logic [5:0] CH_SPACE = 6'd32;
	localparam logic [5:0] CH_MINUS = 6'd45;
	localparam logic [5:0] CH_POINT = 6'd46;
	localparam logic [5:0] CH_ZERO  = 6'd48;

	typedef struct packed {
		logic [7:0] seg_byte_1;
		logic [7:0] seg_byte_2;
		logic [7:0] seg_byte_3;
		logic [7:0] seg_byte_4;
		logic [7:0] seg_byte_5;
		logic [7:0] seg_byte_6;
	} seg_item_t;

	typedef struct packed {
		logic [5:0] sign_char;
		logic [5:0] int_char_0;
		logic [5:0] int_char_1;
		logic [5:0] int_char_2;
		logic [5:0] int_char_3;
		logic [5:0] point_char;
		logic [5:0] frac_char_0;
		logic [5:0] frac_char_1;
		logic [5:0] frac_char_2;
		logic [5:0] frac_char_3;
	} text_t;

	// One decoded display position. Non-digits carry digit value zero.
	typedef struct packed {
		logic [3:0] digit;
		logic       minus;
		logic       point;
	} pos_t;

	typedef struct packed {
		logic                  valid;
		pos_t [NumPos-1:0]     pos;
	} dec_bus_t;

	function automatic pos_t seg_decode(input logic [7:0] b);
		pos_t p;
		p.point = (b & SEG_POINT) != 8'h00;
		p.minus = 1'b0;
		unique case (b[6:0] & SEG_MASK)
			SEG_D0: p.digit = 4'd0;
			SEG_D1: p.digit = 4'd1;
			SEG_D2: p.digit = 4'd2;
			SEG_D3: p.digit = 4'd3;
			SEG_D4: p.digit = 4'd4;
			SEG_D5: p.digit = 4'd5;
			SEG_D6: p.digit = 4'd6;
			SEG_D7: p.digit = 4'd7;
			SEG_D8: p.digit = 4'd8;
			SEG_D9: p.digit = 4'd9;
			SEG_MINUS: begin
				p.digit = 4'd0;
				p.minus = 1'b1;
			end
			default: p.digit = 4'd0;
		endcase
		return p;
	endfunction

endpackage

### rtl/ssat_decode.sv
module ssat_decode
	import ssat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  seg_item_t item,
	output dec_bus_t  dec
);

	seg_item_t item_s1;
	logic      valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		dec.valid  = valid_s1;
		dec.pos[0] = seg_decode(item_s1.seg_byte_1);
		dec.pos[1] = seg_decode(item_s1.seg_byte_2);
		dec.pos[2] = seg_decode(item_s1.seg_byte_3);
		dec.pos[3] = seg_decode(item_s1.seg_byte_4);
		dec.pos[4] = seg_decode(item_s1.seg_byte_5);
		dec.pos[5] = seg_decode(item_s1.seg_byte_6);
	end

endmodule

### rtl/ssat_format.sv
module ssat_format
	import ssat_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dec_bus_t dec,
	output logic     done,
	output text_t    result
);

	pos_t [NumPos-1:0] kept;
	logic              neg;
	logic [2:0]        drop_idx;
	logic [2:0]        klen;
	logic [2:0]        ilen;
	logic              pfound;
	logic [2:0]        iidx [4];
	logic [3:0]        fidx [4];
	logic [5:0]        ichr [4];
	logic [5:0]        fchr [4];
	text_t             text;
	text_t             result_s2;
	logic              done_s2;

	// The first minus is removed; later positions move up by one.
	always_comb begin
		neg      = 1'b0;
		drop_idx = 3'd0;
		for (int i = 0; i < NumPos; i++) begin
			if (!neg && dec.pos[i].minus) begin
				neg      = 1'b1;
				drop_idx = 3'(i);
			end
		end
		for (int j = 0; j < NumPos - 1; j++) begin
			kept[j] = (neg && 3'(j) >= drop_idx) ? dec.pos[j+1] : dec.pos[j];
		end
		kept[NumPos-1] = dec.pos[NumPos-1];
		klen = neg ? 3'(NumPos - 1) : 3'(NumPos);
	end

	// The integer part runs through the first kept point, or all kept positions.
	always_comb begin
		ilen   = klen;
		pfound = 1'b0;
		for (int j = 0; j < NumPos; j++) begin
			if (!pfound && 3'(j) < klen && kept[j].point) begin
				pfound = 1'b1;
				ilen   = 3'(j + 1);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			iidx[i] = ilen - 3'(4 - i);
			if (ilen >= 3'(4 - i)) begin
				ichr[i] = CH_ZERO + {2'b00, kept[iidx[i]].digit};
			end else begin
				ichr[i] = CH_SPACE;
			end
			fidx[i] = {1'b0, ilen} + 4'(i);
			if (fidx[i] < {1'b0, klen}) begin
				fchr[i] = CH_ZERO + {2'b00, kept[fidx[i][2:0]].digit};
			end else begin
				fchr[i] = CH_ZERO;
			end
		end
	end

	always_comb begin
		text.sign_char   = neg ? CH_MINUS : CH_SPACE;
		text.int_char_0  = ichr[0];
		text.int_char_1  = ichr[1];
		text.int_char_2  = ichr[2];
		text.int_char_3  = ichr[3];
		text.point_char  = CH_POINT;
		text.frac_char_0 = fchr[0];
		text.frac_char_1 = fchr[1];
		text.frac_char_2 = fchr[2];
		text.frac_char_3 = fchr[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= dec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dec.valid) begin
			result_s2 <= text;
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule

### rtl/seven_segment_to_aligned_text_core.sv
// Channel   Handshake          Word
// input     start, busy        item   (six seven-segment bytes)
// result    done (strobe)      result (ten six-bit ASCII characters)
//
// One word is accepted every cycle; busy is always low.
// Each accepted word passes through the input register and then the result
// register, which drives done/result.
// Reset clears only the valid flags of the two register stages.
// The receiver cannot stall; each result is shown for one cycle only.
module seven_segment_to_aligned_text_core
	import ssat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  seg_item_t item,
	output logic      done,
	output text_t     result
);

	dec_bus_t dec;

	assign busy = 1'b0;

	ssat_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.item   (item),
		.dec    (dec)
	);

	ssat_format u_format (
		.clk    (clk),
		.arst_n (arst_n),
		.dec    (dec),
		.done   (done),
		.result (result)
	);

endmodule
